>>> rtl/dnd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_pkg: shared types and constants for the DNS name decompressor
// Command and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package dnd_pkg;

	localparam int PACKET_BYTES_DEF   = 512;
	localparam int MAX_NAME_BYTES_DEF = 256;
	localparam int CHUNK_BYTES_DEF    = 8;

	localparam int PTR_HI_BITS = 6;    // offset bits carried in a pointer's first byte
	localparam int PTR_BITS    = 14;   // full pointer target width

	localparam logic [7:0] DOT_CHAR  = 8'h2e;
	localparam logic [1:0] KIND_LAB  = 2'b00;
	localparam logic [1:0] KIND_EXT  = 2'b01;
	localparam logic [1:0] KIND_RSV  = 2'b10;
	localparam logic [1:0] KIND_PTR  = 2'b11;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_APPEND,
		CMD_DECODE
	} cmd_t;

	typedef enum logic [2:0] {
		ST_MORE,
		ST_DONE,
		ST_TRUNC,
		ST_RSVD,
		ST_BADPTR,
		ST_TOOLONG
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_KIND,
		S_PTR,
		S_DATA,
		S_DOT
	} state_t;

endpackage
`default_nettype wire

>>> rtl/dnd_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_req_if: request channel of the DNS name decompressor
// Valid/ready handshake carrying a command, a packet byte and a start offset.
// ----------------------------------------------------------------------------
interface dnd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] packet_byte;
	logic [8:0] start_offset;

	modport source (output valid, output cmd, output packet_byte, output start_offset,
		input ready);
	modport sink (input valid, input cmd, input packet_byte, input start_offset,
		output ready);
endinterface
`default_nettype wire

>>> rtl/dnd_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_rsp_if: result channel of the DNS name decompressor
// Valid/ready handshake carrying one chunk of decoded name and its status.
// ----------------------------------------------------------------------------
interface dnd_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] name_chunk;
	logic [3:0]  chunk_count;
	logic        last_result;
	logic [2:0]  status;
	logic [9:0]  end_offset;

	modport source (output valid, output name_chunk, output chunk_count,
		output last_result, output status, output end_offset, input ready);
	modport sink (input valid, input name_chunk, input chunk_count,
		input last_result, input status, input end_offset, output ready);
endinterface
`default_nettype wire

>>> rtl/dns_name_decompressor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_name_decompressor: DNS name decompression over a local packet store
// Walks length-prefixed labels and compression pointers, emits dotted names.
// ----------------------------------------------------------------------------
// Usage:
//   req carries requests: clear (empties the store), append (writes one byte
//   at the current length; ignored once the store is full) and decode (walks
//   the name that begins at start_offset). Clear and append give no result.
//   rsp carries results of a decode: full chunks of CHUNK_BYTES name bytes with
//   status "more", then one final result with last_result set, the leftover
//   bytes, the status and the offset just after the name (zero unless done).
// Sequencing:
//   A decode is run by a small sequencer around the single read port of the
//   store: a label passes S_HEAD, S_KIND, S_DATA and S_DOT, a pointer S_HEAD,
//   S_KIND and S_PTR; the final result loads as req.ready rises again, and
//   req.ready is low for the whole decode.
// Stalls:
//   The result register frees as it is taken; when it is still full the
//   sequencer holds in place until rsp.ready, so no result is lost.
// Reset:
//   arst_n clears the store length, the sequencer and the result valid flag.
//   Store contents are not cleared; decoding only reads written entries.
// ----------------------------------------------------------------------------
module dns_name_decompressor #(
	parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF,
	parameter int MAX_NAME_BYTES = dnd_pkg::MAX_NAME_BYTES_DEF,
	parameter int CHUNK_BYTES    = dnd_pkg::CHUNK_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dnd_req_if.sink   req,
	dnd_rsp_if.source rsp
);
	import dnd_pkg::*;

	localparam int AW  = $clog2(PACKET_BYTES);
	localparam int LW  = $clog2(PACKET_BYTES + 1);
	localparam int PW  = (LW > 9) ? LW : 9;                 // must also hold start_offset
	localparam int CW  = (PW > PTR_BITS) ? PW : PTR_BITS;   // pointer compare width
	localparam int EW  = (PW > 10) ? PW : 10;
	localparam int NW  = $clog2(MAX_NAME_BYTES + 1);
	localparam int FW  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
	localparam int ACW = 8 * CHUNK_BYTES;

	// packet store
	logic [7:0] mem [PACKET_BYTES];
	logic [7:0] rd_q;
	logic       mem_we;
	logic       rd_en;
	logic [AW-1:0] rd_addr;

	// sequencer and walk state
	state_t              state_q, state_d;
	logic [PW-1:0]       len_q;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       floor_q;
	logic [PW-1:0]       saved_q;
	logic                jumped_q;
	logic [PTR_HI_BITS-1:0] hi_q;     // pointer upper bits
	logic [5:0]          cnt_q;        // label bytes still to read
	logic                pend_q;       // rd_q holds a label byte to push
	logic [NW-1:0]       name_len_q;
	logic [FW-1:0]       fill_q;
	logic [ACW-1:0]      acc_q;

	// result register
	logic        out_valid_q;
	logic [63:0] out_chunk_q;
	logic [3:0]  out_count_q;
	logic        out_last_q;
	logic [2:0]  out_status_q;
	logic [9:0]  out_end_q;

	// control decode
	logic          req_acc;
	logic          emit_ok;
	logic          stall;
	logic          push_en;
	logic [7:0]    push_data;
	logic          fin_en;
	status_t       fin_st;
	logic          chunk_full;
	logic [ACW-1:0] acc_ins;
	logic [1:0]    kind;
	logic [5:0]    lab;
	logic          lab_trunc;
	logic          lab_long;
	logic [PTR_BITS-1:0] tgt;
	logic [CW-1:0] tgt_ext;
	logic          tgt_bad;
	logic [EW-1:0] end_ext;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign mem_we    = req_acc && (req.cmd == CMD_APPEND) && (len_q < PW'(PACKET_BYTES));

	assign emit_ok    = !out_valid_q || rsp.ready;
	assign chunk_full = (fill_q == FW'(CHUNK_BYTES - 1));

	assign kind      = rd_q[7:6];
	assign lab       = rd_q[5:0];
	assign lab_trunc = ({1'b0, pos_q} + (PW+1)'(lab)) > {1'b0, len_q};
	assign lab_long  = ((NW+1)'(name_len_q) + (NW+1)'(lab) + (NW+1)'(1))
		> (NW+1)'(MAX_NAME_BYTES);
	assign tgt       = {hi_q, rd_q};
	assign tgt_ext   = CW'(tgt);
	assign tgt_bad   = tgt_ext >= CW'(floor_q);
	assign end_ext   = EW'(jumped_q ? saved_q : pos_q);

	always_comb begin
		acc_ins = acc_q;
		acc_ins[{fill_q, 3'b000} +: 8] = push_data;
	end

	// sequencer outputs
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = pos_q[AW-1:0];
		push_en   = 1'b0;
		push_data = DOT_CHAR;
		fin_en    = 1'b0;
		fin_st    = ST_DONE;
		case (state_q)
			S_HEAD: begin
				if (pos_q >= len_q) begin
					fin_en = 1'b1;
					fin_st = ST_TRUNC;
				end else begin
					rd_en = 1'b1;
				end
			end
			S_KIND: begin
				if (rd_q == 8'h00) begin
					fin_en = 1'b1;
					fin_st = ST_DONE;
				end else if (kind == KIND_EXT || kind == KIND_RSV) begin
					fin_en = 1'b1;
					fin_st = ST_RSVD;
				end else if (kind == KIND_PTR) begin
					if (pos_q >= len_q) begin
						fin_en = 1'b1;
						fin_st = ST_TRUNC;
					end else begin
						rd_en = 1'b1;
					end
				end else if (lab_trunc) begin
					fin_en = 1'b1;
					fin_st = ST_TRUNC;
				end else if (lab_long) begin
					fin_en = 1'b1;
					fin_st = ST_TOOLONG;
				end
			end
			S_PTR: begin
				if (tgt_bad) begin
					fin_en = 1'b1;
					fin_st = ST_BADPTR;
				end
			end
			S_DATA: begin
				push_en   = pend_q;
				push_data = rd_q;
				rd_en     = (cnt_q != 6'd0);
			end
			S_DOT: begin
				push_en = 1'b1;
			end
			default: begin
			end
		endcase
		stall = (fin_en || (push_en && chunk_full)) && !emit_ok;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc && req.cmd == CMD_DECODE) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				if (!stall) begin
					state_d = fin_en ? S_IDLE : S_KIND;
				end
			end
			S_KIND: begin
				if (!stall) begin
					if (fin_en) begin
						state_d = S_IDLE;
					end else if (kind == KIND_PTR) begin
						state_d = S_PTR;
					end else begin
						state_d = S_DATA;
					end
				end
			end
			S_PTR: begin
				if (!stall) begin
					state_d = fin_en ? S_IDLE : S_HEAD;
				end
			end
			S_DATA: begin
				if (!stall && cnt_q == 6'd0) begin
					state_d = S_DOT;
				end
			end
			S_DOT: begin
				if (!stall) begin
					state_d = S_HEAD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// packet store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[len_q[AW-1:0]] <= req.packet_byte;
		end
		if (rd_en && !stall) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_KIND && kind == KIND_PTR && rd_en && !stall) begin
			hi_q <= rd_q[PTR_HI_BITS-1:0];
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			pos_q      <= '0;
			floor_q    <= '0;
			saved_q    <= '0;
			jumped_q   <= 1'b0;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			name_len_q <= '0;
			fill_q     <= '0;
			acc_q      <= '0;
		end else begin
			state_q <= state_d;
			if (req_acc) begin
				case (req.cmd)
					CMD_CLEAR: begin
						len_q <= '0;
					end
					CMD_APPEND: begin
						if (mem_we) begin
							len_q <= len_q + PW'(1);
						end
					end
					CMD_DECODE: begin
						pos_q      <= PW'(req.start_offset);
						floor_q    <= PW'(req.start_offset);
						saved_q    <= '0;
						jumped_q   <= 1'b0;
						name_len_q <= '0;
						fill_q     <= '0;
						acc_q      <= '0;
					end
					default: begin
					end
				endcase
			end
			if (!stall) begin
				if (rd_en) begin
					pos_q <= pos_q + PW'(1);
				end
				if (state_q == S_KIND && !fin_en && kind == KIND_LAB) begin
					cnt_q  <= lab;
					pend_q <= 1'b0;
				end
				if (state_q == S_PTR && !fin_en) begin
					if (!jumped_q) begin
						saved_q  <= pos_q;
						jumped_q <= 1'b1;
					end
					floor_q <= tgt_ext[PW-1:0];
					pos_q   <= tgt_ext[PW-1:0];
				end
				if (state_q == S_DATA) begin
					pend_q <= (cnt_q != 6'd0);
					if (cnt_q != 6'd0) begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				if (push_en) begin
					name_len_q <= name_len_q + NW'(1);
					if (chunk_full) begin
						fill_q <= '0;
						acc_q  <= '0;
					end else begin
						fill_q <= fill_q + FW'(1);
						acc_q  <= acc_ins;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall && ((push_en && chunk_full) || fin_en)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && push_en && chunk_full) begin
			out_chunk_q  <= 64'(acc_ins);
			out_count_q  <= 4'(CHUNK_BYTES);
			out_last_q   <= 1'b0;
			out_status_q <= ST_MORE;
			out_end_q    <= '0;
		end else if (!stall && fin_en) begin
			out_chunk_q  <= 64'(acc_q);
			out_count_q  <= 4'(fill_q);
			out_last_q   <= 1'b1;
			out_status_q <= fin_st;
			out_end_q    <= (fin_st == ST_DONE) ? end_ext[9:0] : 10'd0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.name_chunk  = out_chunk_q;
	assign rsp.chunk_count = out_count_q;
	assign rsp.last_result = out_last_q;
	assign rsp.status      = out_status_q;
	assign rsp.end_offset  = out_end_q;

	// checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CHUNK_BYTES - 1))
		else $error("chunk fill beyond chunk size");

	a_name_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(NW+1)'(name_len_q) <= (NW+1)'(MAX_NAME_BYTES))
		else $error("name length past limit");

	a_kind_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_KIND |-> pos_q <= len_q)
		else $error("header read beyond packet length");

	a_mid_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |->
		out_count_q == 4'(CHUNK_BYTES) && out_status_q == ST_MORE)
		else $error("intermediate result not a full chunk");

	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE && state_d == S_IDLE |=> out_valid_q && out_last_q)
		else $error("decode ended without final result");

endmodule
`default_nettype wire
